@@ design/pbs_pkg.sv @@
package pbs_pkg;

   // field widths
   localparam int DIST_W     = 10;
   localparam int INTERVAL_W = 12;
   localparam int STEP_W     = 8;
   localparam int ELAPSED_W  = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // distance bounds of the interpolation ramp
   localparam int NEAR_DISTANCE_CM = 10;
   localparam int FAR_DISTANCE_CM  = 50;

   // off-time used when the interval is not longer than the pulse
   localparam logic [INTERVAL_W-1:0] SHORT_OFF_MS = INTERVAL_W'(10);
   localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX  = '1;

   // register reset values
   localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = INTERVAL_W'(80);
   localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RST = INTERVAL_W'(700);
   localparam logic [INTERVAL_W-1:0] ON_TIME_RST      = INTERVAL_W'(30);
   localparam logic [DIST_W-1:0]     CONT_DIST_RST    = DIST_W'(10);
   localparam logic [STEP_W-1:0]     TICK_STEP_RST    = STEP_W'(10);

   // ramp product (distance offset times interval span)
   localparam int PROD_W = DIST_W + INTERVAL_W;

   // exact division by the ramp length: floor(x * RECIP_MULT >> RECIP_SHIFT)
   localparam int DENOM       = FAR_DISTANCE_CM - NEAR_DISTANCE_CM;
   localparam int DENOM_SAFE  = (DENOM > 0) ? DENOM : 1;
   localparam int DENOM_LOG   = $clog2(DENOM_SAFE);
   localparam int RECIP_SHIFT = PROD_W + DENOM_LOG;
   localparam int RECIP_W     = PROD_W + 1;
   localparam longint unsigned RECIP_MULT =
      ((64'd1 << RECIP_SHIFT) + 64'(DENOM_SAFE) - 64'd1) / 64'(DENOM_SAFE);

   // register map
   typedef enum logic [2:0] {
      REG_MIN_INTERVAL = 3'd0,
      REG_MAX_INTERVAL = 3'd1,
      REG_ON_TIME      = 3'd2,
      REG_CONT_DIST    = 3'd3,
      REG_TICK_STEP    = 3'd4
   } reg_index_type;

   // distance class of one tick, carried from the product stage
   typedef struct packed {
      logic silent;
      logic near;
      logic hold_on;
   } dist_class_type;

endpackage

@@ design/pbs_req_if.sv @@
interface pbs_req_if;
   logic                         valid;
   logic                         ready;
   logic [pbs_pkg::DIST_W-1:0]   distance_cm;
   logic                         no_echo;

   modport source (output valid, output distance_cm, output no_echo, input ready);
   modport sink   (input valid, input distance_cm, input no_echo, output ready);
endinterface

@@ design/pbs_rsp_if.sv @@
interface pbs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             buzzer_on;
   logic [pbs_pkg::INTERVAL_W-1:0]   interval_ms;

   modport source (output valid, output buzzer_on, output interval_ms, input ready);
   modport sink   (input valid, input buzzer_on, input interval_ms, output ready);
endinterface

@@ design/proximity_beep_scheduler.sv @@
// Parking buzzer scheduler: each tick transfer (distance, no-echo flag) yields one
// result transfer with the buzzer level after that tick and the beep interval for the
// distance (0 means silent). One tick is accepted every clock cycle while the result
// channel is not stalled; a result passes the input register, the ramp product register
// and the result register; the buzzer state (elapsed time, beeping flag) is updated
// when a tick leaves the product stage, which lets ticks run back to back.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12, 16: minimum interval,
// maximum interval, on-time, continuous distance, tick step. Write them only while no
// tick is in flight.
module proximity_beep_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   pbs_req_if.sink                           req_chan,
   pbs_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pbs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pbs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pbs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int IW = pbs_pkg::INTERVAL_W;
   localparam int DW = pbs_pkg::DIST_W;
   localparam int EW = pbs_pkg::ELAPSED_W;
   localparam int SW = pbs_pkg::STEP_W;
   localparam int PW = pbs_pkg::PROD_W;
   localparam int RW = pbs_pkg::RECIP_W;
   localparam int CSR_IDX_HI = pbs_pkg::CSR_ADDR_W - 1;

   // configuration registers
   logic [IW-1:0] min_interval_ff;
   logic [IW-1:0] max_interval_ff;
   logic [IW-1:0] on_time_ff;
   logic [DW-1:0] cont_dist_ff;
   logic [SW-1:0] tick_step_ff;

   pbs_pkg::reg_index_type csr_index;
   logic                   csr_write;

   // pipeline registers
   logic                          s1_valid_ff;
   logic [DW-1:0]                 s1_dist_ff;
   logic                          s1_no_echo_ff;
   logic                          s2_valid_ff;
   pbs_pkg::dist_class_type       s2_class_ff;
   logic [PW-1:0]                 s2_prod_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_buzzer_ff;
   logic [IW-1:0]                 rsp_interval_ff;

   // buzzer state
   logic [EW-1:0] elapsed_ff;
   logic [EW-1:0] elapsed_in;
   logic          beeping_ff;
   logic          beeping_in;

   // stage control
   logic out_free;
   logic s2_free;
   logic s1_move;
   logic s2_move;

   // stage 1 logic
   logic [IW-1:0]           span;
   logic [DW-1:0]           dist_offset;
   pbs_pkg::dist_class_type s1_class;

   // stage 2 logic
   logic [PW+RW-1:0] quot_full;
   logic [IW-1:0]    quot;
   logic [IW-1:0]    interval;
   logic [IW-1:0]    off_time;
   logic [EW:0]      elapsed_sum;
   logic [EW-1:0]    elapsed_sat;

   // ------------------------------------------------------------------
   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = pbs_pkg::reg_index_type'(csr_paddr[CSR_IDX_HI:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= pbs_pkg::MIN_INTERVAL_RST;
         max_interval_ff <= pbs_pkg::MAX_INTERVAL_RST;
         on_time_ff      <= pbs_pkg::ON_TIME_RST;
         cont_dist_ff    <= pbs_pkg::CONT_DIST_RST;
         tick_step_ff    <= pbs_pkg::TICK_STEP_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            pbs_pkg::REG_MIN_INTERVAL: min_interval_ff <= csr_pwdata[IW-1:0];
            pbs_pkg::REG_MAX_INTERVAL: max_interval_ff <= csr_pwdata[IW-1:0];
            pbs_pkg::REG_ON_TIME:      on_time_ff      <= csr_pwdata[IW-1:0];
            pbs_pkg::REG_CONT_DIST:    cont_dist_ff    <= csr_pwdata[DW-1:0];
            pbs_pkg::REG_TICK_STEP:    tick_step_ff    <= csr_pwdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_index)
         pbs_pkg::REG_MIN_INTERVAL: csr_prdata = pbs_pkg::CSR_DATA_W'(min_interval_ff);
         pbs_pkg::REG_MAX_INTERVAL: csr_prdata = pbs_pkg::CSR_DATA_W'(max_interval_ff);
         pbs_pkg::REG_ON_TIME:      csr_prdata = pbs_pkg::CSR_DATA_W'(on_time_ff);
         pbs_pkg::REG_CONT_DIST:    csr_prdata = pbs_pkg::CSR_DATA_W'(cont_dist_ff);
         pbs_pkg::REG_TICK_STEP:    csr_prdata = pbs_pkg::CSR_DATA_W'(tick_step_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // handshake and stage advance
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s2_free        = !s2_valid_ff || out_free;
   assign s2_move        = s2_valid_ff && out_free;
   assign s1_move        = s1_valid_ff && s2_free;
   assign req_chan.ready = !s1_valid_ff || s2_free;

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_dist_ff    <= req_chan.distance_cm;
         s1_no_echo_ff <= req_chan.no_echo;
      end
   end

   // distance class and ramp span
   always_comb begin
      s1_class.silent  = s1_no_echo_ff || (s1_dist_ff >= DW'(pbs_pkg::FAR_DISTANCE_CM));
      s1_class.near    = (s1_dist_ff <= DW'(pbs_pkg::NEAR_DISTANCE_CM));
      s1_class.hold_on = (s1_dist_ff <= cont_dist_ff);
      span             = (max_interval_ff >= min_interval_ff) ?
                         (max_interval_ff - min_interval_ff) : '0;
      dist_offset      = s1_dist_ff - DW'(pbs_pkg::NEAR_DISTANCE_CM);
   end

   // stage 2: ramp product register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_class_ff <= s1_class;
         s2_prod_ff  <= PW'(dist_offset) * PW'(span);
      end
   end

   // divide by ramp length through reciprocal, pick interval
   always_comb begin
      quot_full = (PW + RW)'(s2_prod_ff) * (PW + RW)'(RW'(pbs_pkg::RECIP_MULT));
      quot      = quot_full[pbs_pkg::RECIP_SHIFT +: IW];
      if (s2_class_ff.silent) begin
         interval = '0;
      end else if (s2_class_ff.near) begin
         interval = min_interval_ff;
      end else begin
         interval = min_interval_ff + quot;
      end
   end

   // buzzer state next value
   always_comb begin
      elapsed_sum = {1'b0, elapsed_ff} + (EW + 1)'(tick_step_ff);
      elapsed_sat = elapsed_sum[EW] ? pbs_pkg::ELAPSED_MAX : elapsed_sum[EW-1:0];
      off_time    = (interval > on_time_ff) ? (interval - on_time_ff) : pbs_pkg::SHORT_OFF_MS;
      beeping_in  = beeping_ff;
      elapsed_in  = elapsed_sat;
      if (interval == '0) begin
         beeping_in = 1'b0;
         elapsed_in = '0;
      end else if (s2_class_ff.hold_on) begin
         beeping_in = 1'b1;
         elapsed_in = '0;
      end else if (beeping_ff) begin
         if (elapsed_sat >= EW'(on_time_ff)) begin
            beeping_in = 1'b0;
            elapsed_in = '0;
         end
      end else begin
         if (elapsed_sat >= EW'(off_time)) begin
            beeping_in = 1'b1;
            elapsed_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beeping_ff <= 1'b0;
         elapsed_ff <= '0;
      end else if (s2_move) begin
         beeping_ff <= beeping_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // stage 3: result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_buzzer_ff   <= beeping_in;
         rsp_interval_ff <= interval;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.buzzer_on   = rsp_buzzer_ff;
   assign rsp_chan.interval_ms = rsp_interval_ff;

   // ------------------------------------------------------------------
   // a silent result never drives the buzzer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_interval_ff == '0)) |-> !rsp_buzzer_ff)
      else $error("buzzer on with silent interval");

   // every buzzer change restarts the elapsed count
   assert property (@(posedge clock) disable iff (reset)
      $rose(beeping_ff) |-> (elapsed_ff == '0))
      else $error("elapsed time not cleared on buzzer start");

   assert property (@(posedge clock) disable iff (reset)
      $fell(beeping_ff) |-> (elapsed_ff == '0))
      else $error("elapsed time not cleared on buzzer stop");

   // a tick leaving stage 1 lands in stage 2
   assert property (@(posedge clock) disable iff (reset)
      s1_move |=> s2_valid_ff)
      else $error("tick lost between input and product stage");

endmodule
